// File: hw/rtl/lzp_byte_compressor_top_defines.svh
// Assertion macros for the LZP byte compressor.
// Used by lzp_byte_compressor_top; expects i_clk and i_rst_n in scope.
`ifndef LZP_BYTE_COMPRESSOR_TOP_DEFINES_SVH
`define LZP_BYTE_COMPRESSOR_TOP_DEFINES_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define LZP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define LZP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lzp_pkg.sv
// Shared types and constants for the LZP byte compressor.
// No dependencies; every RTL module of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lzp_pkg;

    localparam int HASH_BITS    = 8;
    localparam int TABLE_SIZE   = 1 << HASH_BITS;
    localparam int HASH_SHIFT   = 3;
    localparam int GROUP_TOKENS = 8;
    localparam int GROUP_IDX_W  = 3;
    localparam int FILL_W       = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    localparam logic [7:0] RUN_LIMIT = 8'd255;
    localparam logic [7:0] END_RUN   = 8'd0;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Tokens caused by one input item: an optional run token first, then an
    // optional second token (a literal, or the end marker run).
    typedef struct packed {
        logic       has_run;
        logic [7:0] run_len;
        logic       has_tok2;
        logic       tok2_is_run;
        logic [7:0] tok2_byte;
        logic       is_end;
    } t_tok_ent;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TOK2,
        ST_MASK,
        ST_PAY
    } t_back_state;

endpackage

`default_nettype wire

// File: hw/rtl/lzp_byte_compressor_top.sv
// LZP byte compressor: the front end takes one byte per cycle unless the token queue is full,
// and passes tokens through its stage register into the queue. The packer adds one token per
// cycle while it is not sending a group and sends a full group in nine beats, so on a stream of
// literals the packer and its single output port set the rate.
// Reset is synchronous, active low; table valid bits clear at once, no clearing pass.
// Depends on lzp_pkg, lzp_front, lzp_tokq, lzp_back and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lzp_byte_compressor_top_defines.svh"

module lzp_byte_compressor_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_op,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item,
    output logic            o_stream_end
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    lzp_pkg::t_tok_ent q_in;
    lzp_pkg::t_tok_ent q_out;

    lzp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_in_byte (i_in_byte),
        .o_push    (q_push),
        .o_ent     (q_in),
        .i_q_full  (q_full)
    );

    lzp_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_ent   (q_out),
        .o_empty (q_empty)
    );

    lzp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ent          (q_out),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_stream_end   (o_stream_end)
    );

    `LZP_ASSERT_IMP(a_push_not_full, q_push, !q_full, "token pushed into a full queue")
    `LZP_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty, "token popped from an empty queue")
    `LZP_ASSERT_IMP(a_end_is_last, o_out_valid && o_stream_end, o_last_of_item,
        "stream end beat not marked as last of its item")
    `LZP_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_empty, "queue empty after a push")

endmodule

`default_nettype wire

// File: hw/rtl/lzp_front.sv
// Front end: accepts bytes, looks up the prediction table, tracks runs and
// produces token entries. Depends on lzp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_in_byte,
    output logic                   o_push,
    output lzp_pkg::t_tok_ent      o_ent,
    input  wire logic              i_q_full
);

    logic [7:0]                   r_table [lzp_pkg::TABLE_SIZE];
    logic [lzp_pkg::TABLE_SIZE-1:0] r_valid;
    logic [lzp_pkg::HASH_BITS-1:0] r_hash;
    logic [lzp_pkg::HASH_BITS-1:0] n_hash;
    logic [lzp_pkg::HASH_BITS+7:0] hash_sum;
    logic [7:0]                   r_run;
    logic [7:0]                   n_run;

    logic                         r_s1_valid;
    logic                         r_s1_op;
    logic [7:0]                   r_s1_byte;
    logic [lzp_pkg::HASH_BITS-1:0] r_s1_addr;
    logic [7:0]                   r_s1_rd;
    logic                         r_s1_vld;
    logic                         r_s1_fw_hit;
    logic                         r_s1_fw_clr;
    logic [7:0]                   r_s1_fw_byte;

    logic                         accept;
    logic                         s1_fire;
    logic [7:0]                   pred;
    logic                         is_end;
    logic                         hit;
    logic                         miss;
    logic [7:0]                   run_inc;
    logic                         hit_limit;

    assign o_ready = !r_s1_valid || !i_q_full;
    assign accept  = i_valid && o_ready;
    assign s1_fire = r_s1_valid && !i_q_full;

    assign hash_sum = {5'b0, r_hash, 3'b0} + {{lzp_pkg::HASH_BITS{1'b0}}, i_in_byte};
    assign n_hash   = (i_op == lzp_pkg::OP_END) ? '0 : hash_sum[lzp_pkg::HASH_BITS-1:0];

    // The item one ahead writes the table in the cycle this item reads it, and
    // an end item clears it then; both cases are forwarded here.
    always_comb begin
        if (r_s1_fw_clr) begin
            pred = 8'd0;
        end else if (r_s1_fw_hit) begin
            pred = r_s1_fw_byte;
        end else if (r_s1_vld) begin
            pred = r_s1_rd;
        end else begin
            pred = 8'd0;
        end
    end

    assign is_end    = (r_s1_op == lzp_pkg::OP_END);
    assign hit       = !is_end && (r_s1_byte == pred);
    assign miss      = !is_end && !hit;
    assign run_inc   = r_run + 8'd1;
    assign hit_limit = hit && (run_inc == lzp_pkg::RUN_LIMIT);

    always_comb begin
        o_ent.has_run     = hit ? hit_limit : (r_run != 8'd0);
        o_ent.run_len     = hit ? lzp_pkg::RUN_LIMIT : r_run;
        o_ent.has_tok2    = !hit;
        o_ent.tok2_is_run = is_end;
        o_ent.tok2_byte   = is_end ? lzp_pkg::END_RUN : r_s1_byte;
        o_ent.is_end      = is_end;
        if (hit) begin
            n_run = hit_limit ? 8'd0 : run_inc;
        end else begin
            n_run = 8'd0;
        end
    end

    assign o_push = s1_fire && (o_ent.has_run || o_ent.has_tok2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= '0;
            r_run      <= 8'd0;
            r_s1_valid <= 1'b0;
            r_valid    <= '0;
        end else begin
            if (accept) begin
                r_hash <= n_hash;
            end
            if (s1_fire) begin
                r_run <= n_run;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && is_end) begin
                r_valid <= '0;
            end else if (s1_fire && miss) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && miss) begin
            r_table[r_s1_addr] <= r_s1_byte;
        end
        if (accept) begin
            r_s1_rd <= r_table[r_hash];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= i_op;
            r_s1_byte    <= i_in_byte;
            r_s1_addr    <= r_hash;
            r_s1_vld     <= r_valid[r_hash];
            r_s1_fw_hit  <= s1_fire && miss && (r_s1_addr == r_hash);
            r_s1_fw_clr  <= s1_fire && is_end;
            r_s1_fw_byte <= r_s1_byte;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lzp_tokq.sv
// Short token queue between the front end and the group packer.
// Depends on lzp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module lzp_tokq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire lzp_pkg::t_tok_ent i_ent,
    output logic                   o_full,
    input  wire logic              i_pop,
    output lzp_pkg::t_tok_ent      o_ent,
    output logic                   o_empty
);

    lzp_pkg::t_tok_ent           r_mem [lzp_pkg::QUEUE_DEPTH];
    logic [lzp_pkg::QUEUE_AW-1:0] r_wr;
    logic [lzp_pkg::QUEUE_AW-1:0] r_rd;
    logic [lzp_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (lzp_pkg::QUEUE_AW+1)'(lzp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_ent   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lzp_back.sv
// Back end: packs tokens into groups and sends each group (mask beat, then
// payload beats) through an output register. Depends on lzp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lzp_pkg::t_tok_ent i_ent,
    input  wire logic              i_q_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_of_item,
    output logic                   o_stream_end
);

    lzp_pkg::t_back_state            r_state;
    lzp_pkg::t_back_state            n_state;
    lzp_pkg::t_tok_ent               r_ent;
    logic [7:0]                      r_pay [lzp_pkg::GROUP_TOKENS];
    logic [7:0]                      r_mask;
    logic [lzp_pkg::FILL_W-1:0]      r_fill;
    logic [lzp_pkg::GROUP_IDX_W-1:0] r_idx;
    logic                            r_more;
    logic                            r_emit_last;
    logic                            r_emit_end;
    logic                            r_o_valid;
    logic [7:0]                      r_o_byte;
    logic                            r_o_last;
    logic                            r_o_end;

    logic                            out_free;
    logic                            add_go;
    logic                            tok_is_run;
    logic [7:0]                      tok_byte;
    logic                            more;
    logic                            ent_end;
    logic [lzp_pkg::FILL_W-1:0]      fill_after;
    logic                            flush;
    logic [lzp_pkg::GROUP_IDX_W-1:0] slot;
    logic                            pay_last;
    logic                            load_out;
    logic [7:0]                      out_byte;
    logic                            out_last;
    logic                            out_end;
    logic                            emit_done;

    assign out_free   = !r_o_valid || i_out_ready;
    assign slot       = r_fill[lzp_pkg::GROUP_IDX_W-1:0];
    assign fill_after = r_fill + 1'b1;
    assign pay_last   = ({1'b0, r_idx} == (r_fill - 1'b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        add_go     = 1'b0;
        tok_is_run = 1'b0;
        tok_byte   = 8'd0;
        more       = 1'b0;
        ent_end    = 1'b0;
        load_out   = 1'b0;
        out_byte   = 8'd0;
        out_last   = 1'b0;
        out_end    = 1'b0;
        emit_done  = 1'b0;
        flush      = 1'b0;
        unique case (r_state)
            lzp_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    add_go  = 1'b1;
                    more    = i_ent.has_run && i_ent.has_tok2;
                    ent_end = i_ent.is_end;
                    if (i_ent.has_run) begin
                        tok_is_run = 1'b1;
                        tok_byte   = i_ent.run_len;
                    end else begin
                        tok_is_run = i_ent.tok2_is_run;
                        tok_byte   = i_ent.tok2_byte;
                    end
                end
            end
            lzp_pkg::ST_TOK2: begin
                add_go     = 1'b1;
                tok_is_run = r_ent.tok2_is_run;
                tok_byte   = r_ent.tok2_byte;
                ent_end    = r_ent.is_end;
            end
            lzp_pkg::ST_MASK: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_byte = r_mask;
                    n_state  = lzp_pkg::ST_PAY;
                end
            end
            lzp_pkg::ST_PAY: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_byte = r_pay[r_idx];
                    out_last = pay_last && r_emit_last;
                    out_end  = pay_last && r_emit_end;
                    if (pay_last) begin
                        emit_done = 1'b1;
                        n_state   = r_more ? lzp_pkg::ST_TOK2 : lzp_pkg::ST_IDLE;
                    end
                end
            end
        endcase
        // A full group goes out at once; an end item also sends a partial one.
        if (add_go) begin
            flush = (fill_after == lzp_pkg::FILL_W'(lzp_pkg::GROUP_TOKENS)) ||
                    (!more && ent_end);
            if (flush) begin
                n_state = lzp_pkg::ST_MASK;
            end else if (more) begin
                n_state = lzp_pkg::ST_TOK2;
            end else begin
                n_state = lzp_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_mask    <= 8'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (add_go) begin
                r_fill <= fill_after;
                if (tok_is_run) begin
                    r_mask[slot] <= 1'b1;
                end
            end
            if (emit_done) begin
                r_fill <= '0;
                r_mask <= 8'd0;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (add_go) begin
            r_pay[slot] <= tok_byte;
        end
        if (o_pop) begin
            r_ent <= i_ent;
        end
        if (add_go && flush) begin
            r_more      <= more;
            // The second token of a data item only opens a new group, so a group
            // sent by its first token already holds the item's last beat.
            r_emit_last <= !more || !ent_end;
            r_emit_end  <= ent_end && !more;
        end
        if (load_out) begin
            r_o_byte <= out_byte;
            r_o_last <= out_last;
            r_o_end  <= out_end;
            r_idx    <= (r_state == lzp_pkg::ST_MASK) ? '0 : r_idx + 1'b1;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_last_of_item = r_o_last;
    assign o_stream_end   = r_o_end;

endmodule

`default_nettype wire

// File: tb/lzp_byte_compressor_top_tb.sv
// Self-checking testbench for lzp_byte_compressor_top: byte streams go in, compressed beats are
// predicted by a scoreboard class and compared as they come out.
// Depends on lzp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module lzp_byte_compressor_top_tb;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 30;

    typedef enum {
        KIND_NOISE,
        KIND_CONST,
        KIND_REPEAT,
        KIND_MIXED
    } t_text_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ends;
    } t_comp_beat;

    // Predicts the compressed beats of each accepted input and checks the beats that leave.
    class lzp_scoreboard;
        logic [7:0]                    guess [lzp_pkg::TABLE_SIZE];
        logic [lzp_pkg::HASH_BITS-1:0] ctx;
        logic [7:0]                    run_len;
        logic [7:0]                    grp_mask;
        int                            grp_fill;
        logic [7:0]                    grp_pay [lzp_pkg::GROUP_TOKENS];
        t_comp_beat                    item_beats [$];
        t_comp_beat                    expected_q [$];
        int                            errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            foreach (guess[k]) guess[k] = '0;
            foreach (grp_pay[k]) grp_pay[k] = '0;
            ctx      = '0;
            run_len  = '0;
            grp_mask = '0;
            grp_fill = 0;
        endfunction

        function void put_beat(logic [7:0] data);
            t_comp_beat b;
            b.data = data;
            b.last = 1'b0;
            b.ends = 1'b0;
            item_beats.push_back(b);
        endfunction

        function void send_group();
            if (grp_fill == 0) return;
            put_beat(grp_mask);
            for (int k = 0; k < grp_fill; k++) put_beat(grp_pay[k]);
            grp_mask = '0;
            grp_fill = 0;
        endfunction

        function void add_token(bit is_run, logic [7:0] payload);
            if (is_run) grp_mask[grp_fill] = 1'b1;
            grp_pay[grp_fill] = payload;
            grp_fill++;
            if (grp_fill == lzp_pkg::GROUP_TOKENS) send_group();
        endfunction

        function void note_input(logic op, logic [7:0] b);
            item_beats.delete();
            if (op == lzp_pkg::OP_END) begin
                if (run_len != 0) add_token(1'b1, run_len);
                add_token(1'b1, lzp_pkg::END_RUN);
                send_group();
                clear_state();
            end else if (b == guess[ctx]) begin
                ctx = (ctx << lzp_pkg::HASH_SHIFT) + b;
                run_len++;
                if (run_len == lzp_pkg::RUN_LIMIT) begin
                    add_token(1'b1, lzp_pkg::RUN_LIMIT);
                    run_len = '0;
                end
            end else begin
                if (run_len != 0) begin
                    add_token(1'b1, run_len);
                    run_len = '0;
                end
                add_token(1'b0, b);
                guess[ctx] = b;
                ctx = (ctx << lzp_pkg::HASH_SHIFT) + b;
            end
            if (item_beats.size() != 0) begin
                item_beats[item_beats.size() - 1].last = 1'b1;
                item_beats[item_beats.size() - 1].ends = (op == lzp_pkg::OP_END);
            end
            foreach (item_beats[k]) expected_q.push_back(item_beats[k]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic [7:0] data, logic last, logic ends);
            t_comp_beat want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("beat 0x%02h with nothing expected", data));
            end else begin
                want = expected_q.pop_front();
                if (data !== want.data)
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              data, want.data));
                if (last !== want.last)
                    report_mismatch($sformatf("last_of_item %b, expected %b", last, want.last));
                if (ends !== want.ends)
                    report_mismatch($sformatf("stream_end %b, expected %b", ends, want.ends));
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_op        = lzp_pkg::OP_DATA;
    logic [7:0] i_in_byte   = '0;
    logic       i_out_ready = 1'b0;
    logic       o_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_item;
    logic       o_stream_end;

    lzp_scoreboard sb;
    int            snd_idle_pct  = 0;
    int            rcv_stall_pct = 0;
    int            items_sent    = 0;
    int            cycle_cnt     = 0;

    lzp_byte_compressor_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_stream_end   (o_stream_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: check every accepted beat and pick the next ready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat(o_out_byte, o_last_of_item, o_stream_end);
        i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Called at a rising edge; returns at the edge where the beat is accepted.
    task automatic push_item(logic op, logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(op, b);
        items_sent++;
    endtask

    // One stream of data bytes closed by an end item; the end carries a junk byte.
    task automatic send_stream(t_text_kind kind, int len);
        logic [7:0] pat [8];
        int         plen;
        logic [7:0] b;
        plen = $urandom_range(1, 6);
        foreach (pat[k]) pat[k] = 8'($urandom);
        for (int n = 0; n < len; n++) begin
            case (kind)
                KIND_NOISE:  b = 8'($urandom);
                KIND_CONST:  b = pat[0];
                KIND_REPEAT: b = pat[n % plen];
                default:     b = ($urandom_range(7) == 0) ? 8'($urandom) : pat[n % plen];
            endcase
            push_item(lzp_pkg::OP_DATA, b);
        end
        push_item(lzp_pkg::OP_END, 8'($urandom));
    endtask

    task automatic run_phase(int snd_pct, int rcv_pct);
        int         stop_at;
        int         len;
        t_text_kind kind;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) begin
            kind = t_text_kind'($urandom_range(3));
            // Mostly short streams, now and then a long one so runs and full groups build up.
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
            send_stream(kind, len);
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // An end with no data before it.
        push_item(lzp_pkg::OP_END, 8'hFF);
        // Run, extreme bytes as literals, then an end with a run open over a group of seven.
        push_item(lzp_pkg::OP_DATA, 8'h00);
        push_item(lzp_pkg::OP_DATA, 8'hFF);
        push_item(lzp_pkg::OP_DATA, 8'h80);
        push_item(lzp_pkg::OP_DATA, 8'h01);
        push_item(lzp_pkg::OP_DATA, 8'h7F);
        push_item(lzp_pkg::OP_DATA, 8'h55);
        push_item(lzp_pkg::OP_DATA, 8'hAA);
        push_item(lzp_pkg::OP_DATA, 8'h00);
        push_item(lzp_pkg::OP_DATA, 8'h00);
        push_item(lzp_pkg::OP_END, 8'h00);

        run_phase(0, 0);
        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(14, 14);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected beats never came", sb.pending()));
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: lzp_byte_compressor_top.f
+incdir+hw/rtl
hw/rtl/lzp_pkg.sv
hw/rtl/lzp_front.sv
hw/rtl/lzp_tokq.sv
hw/rtl/lzp_back.sv
hw/rtl/lzp_byte_compressor_top.sv
tb/lzp_byte_compressor_top_tb.sv
